// File: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared types, operation codes and defaults for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;

    // Operation codes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MIN  = 4'd4;
    localparam logic [3:0] OP_MAX  = 4'd5;
    localparam logic [3:0] OP_INC  = 4'd6;
    localparam logic [3:0] OP_DEC  = 4'd7;
    localparam logic [3:0] OP_TOI  = 4'd8;
    localparam logic [3:0] OP_FROMI = 4'd9;

    typedef struct packed {
        logic        [3:0]  req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               div_by_zero;
    } t_res;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [3:0]  op;
        logic        less;
        logic        equal;
        logic        greater;
        logic        dz;
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] simple;
    } t_cls;

endpackage

// File: hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Classifies a request: compare flags, signs, magnitudes and simple results.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  fpa_pkg::t_req i_req,
    output fpa_pkg::t_cls o_cls
);

    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic               w_less;
    logic               w_greater;

    assign w_a       = i_req.operand_a;
    assign w_b       = i_req.operand_b;
    assign w_less    = w_a < w_b;
    assign w_greater = w_a > w_b;

    // Flags, sign and magnitudes for the multiplier and divider, and the
    // results that need no long arithmetic.
    always_comb begin
        o_cls.op      = i_req.req_type;
        o_cls.less    = w_less;
        o_cls.equal   = (w_a == w_b);
        o_cls.greater = w_greater;
        o_cls.dz      = (i_req.req_type == fpa_pkg::OP_DIV) && (w_b == 32'sd0);
        o_cls.neg     = w_a[31] ^ w_b[31];
        o_cls.ma      = w_a[31] ? 32'(-w_a) : 32'(w_a);
        o_cls.mb      = w_b[31] ? 32'(-w_b) : 32'(w_b);
        unique case (i_req.req_type)
            fpa_pkg::OP_ADD:   o_cls.simple = 32'(w_a + w_b);
            fpa_pkg::OP_SUB:   o_cls.simple = 32'(w_a - w_b);
            fpa_pkg::OP_MIN:   o_cls.simple = w_less ? w_a : w_b;
            fpa_pkg::OP_MAX:   o_cls.simple = w_greater ? w_a : w_b;
            fpa_pkg::OP_INC:   o_cls.simple = 32'(w_a + 32'sd1);
            fpa_pkg::OP_DEC:   o_cls.simple = 32'(w_a - 32'sd1);
            fpa_pkg::OP_TOI:   o_cls.simple = 32'(w_a >>> FRAC_BITS);
            fpa_pkg::OP_FROMI: o_cls.simple = 32'(w_a << FRAC_BITS);
            default:           o_cls.simple = 32'd0;
        endcase
    end

endmodule

// File: hdl/fpa_queue.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU request queue
// Two-entry queue between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpa_pkg::t_cls i_data,
    input  logic          i_pop,
    output fpa_pkg::t_cls o_data,
    output logic          o_empty,
    output logic          o_full
);

    fpa_pkg::t_cls r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          w_pop;
    logic          w_push;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign w_pop   = i_pop && !o_empty;
    assign w_push  = i_push && !o_full;
    assign o_data  = r_mem[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU execution pipeline
// Multiplier stage, one restoring division step per stage, result format.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fpa_pkg::t_cls i_cls,
    output logic          o_done,
    output fpa_pkg::t_res o_result
);

    localparam int DW = 32 + FRAC_BITS;

    logic          r_v    [DW+1];
    fpa_pkg::t_cls r_cls  [DW+1];
    logic [31:0]   r_rem  [DW+1];
    logic [DW-1:0] r_dq   [DW+1];
    logic [63:0]   r_prod;
    logic [32:0]   w_t    [DW+1];
    logic          w_ge   [DW+1];
    fpa_pkg::t_cls w_cls1;
    logic signed [63:0] w_sprod;
    logic          r_done;
    fpa_pkg::t_res r_res;

    // Divider step for each stage.
    always_comb begin
        w_t[0]  = 33'd0;
        w_ge[0] = 1'b0;
        for (int k = 1; k <= DW; k++) begin
            w_t[k]  = {r_rem[k-1], r_dq[k-1][DW-1]};
            w_ge[k] = (w_t[k] >= {1'b0, r_cls[k-1].mb});
        end
    end

    // Multiplier result is formatted in the first divider stage.
    always_comb begin
        w_sprod = r_cls[0].neg ? -$signed(r_prod) : $signed(r_prod);
        w_cls1  = r_cls[0];
        if (r_cls[0].op == fpa_pkg::OP_MUL) begin
            w_cls1.simple = 32'(w_sprod >>> FRAC_BITS);
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_cls[0] <= i_cls;
        r_prod   <= 64'(i_cls.ma) * 64'(i_cls.mb);
        r_rem[0] <= 32'd0;
        r_dq[0]  <= DW'(i_cls.ma) << FRAC_BITS;
        for (int k = 1; k <= DW; k++) begin
            r_cls[k] <= (k == 1) ? w_cls1 : r_cls[k-1];
            r_rem[k] <= w_ge[k] ? 32'(w_t[k] - {1'b0, r_cls[k-1].mb}) : w_t[k][31:0];
            r_dq[k]  <= {r_dq[k-1][DW-2:0], w_ge[k]};
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) r_v[k] <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= DW; k++) r_v[k] <= r_v[k-1];
            r_done <= r_v[DW];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_res.a_less      <= r_cls[DW].less;
        r_res.a_equal     <= r_cls[DW].equal;
        r_res.a_greater   <= r_cls[DW].greater;
        r_res.div_by_zero <= r_cls[DW].dz;
        if (r_cls[DW].op == fpa_pkg::OP_DIV) begin
            if (r_cls[DW].dz) begin
                r_res.result <= 32'sd0;
            end else if (r_cls[DW].neg) begin
                r_res.result <= 32'(-r_dq[DW][31:0]);
            end else begin
                r_res.result <= r_dq[DW][31:0];
            end
        end else begin
            r_res.result <= r_cls[DW].simple;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// File: hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed fixed-point ALU with a classifying front end, a request queue and a
// pipelined multiply/divide back end.
// ----------------------------------------------------------------------------
// Path: a transferred request waits in the queue, then passes stage 0, the
// 32 + FRAC_BITS divider stages and the output register, for every operation.
// Throughput: one request per cycle; the divider spends one pipeline stage
// per quotient bit (32 + FRAC_BITS stages) so every request keeps its slot.
// busy never rises in operation, since the back end drains the queue every cycle.
// Reset: synchronous, active low; clears the queue and all valid bits.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fpa_pkg::t_req i_req,
    output logic          o_done,
    output fpa_pkg::t_res o_result
);

    fpa_pkg::t_cls w_cls;
    fpa_pkg::t_cls w_q_cls;
    logic          w_empty;
    logic          w_full;

    // Classify the incoming request.
    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_req (i_req),
        .o_cls (w_cls)
    );

    // Queue between front and back; the back drains it every cycle.
    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !w_full),
        .i_data  (w_cls),
        .i_pop   (!w_empty),
        .o_data  (w_q_cls),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    assign busy = w_full;

    // Execute.
    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_cls    (w_q_cls),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
